// File: hdl/orc_pkg.sv
package orc_pkg;

  // Angle constants in centidegrees.
  localparam logic [15:0] FULL_TURN = 16'd36000;
  localparam logic [15:0] MAX_TURN  = 16'd35999;
  localparam int          HALF_TURN = 18000;

  // Wheel magnitude difference above which the compass is trusted instead.
  localparam logic [31:0] MAX_WHEEL_DISAGREE = 32'd100;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ANGLE_PER_TICK = 3'd0;
  localparam logic [2:0] CFG_CLOSE_ENOUGH   = 3'd1;
  localparam logic [2:0] CFG_SLOW_THRESHOLD = 3'd2;
  localparam logic [2:0] CFG_STOP_SPEED     = 3'd3;
  localparam logic [2:0] CFG_FAST_FWD_SPEED = 3'd4;
  localparam logic [2:0] CFG_FAST_REV_SPEED = 3'd5;
  localparam logic [2:0] CFG_SLOW_FWD_SPEED = 3'd6;
  localparam logic [2:0] CFG_SLOW_REV_SPEED = 3'd7;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_SET   = 2'd2
  } op_t;

  typedef struct packed {
    logic [15:0] angle_per_tick;
    logic [14:0] close_enough;
    logic [14:0] slow_threshold;
    logic [7:0]  stop_speed;
    logic [7:0]  fast_fwd_speed;
    logic [7:0]  fast_rev_speed;
    logic [7:0]  slow_fwd_speed;
    logic [7:0]  slow_rev_speed;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [15:0]        target_angle;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [15:0]        compass_angle;
    logic               compass_fresh;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  left_speed;
    logic [7:0]  right_speed;
    logic [15:0] heading;
    logic [15:0] progress;
    logic        finished;
    logic        stalled;
  } out_item_t;

  // Odometry estimate handed from the turn estimator to the state update.
  typedef struct packed {
    logic [15:0] turn;
    logic        use_compass;
    logic        dir_pos;
  } turn_est_t;

  // Fold an angle of 36000 or more back into range once.
  function automatic logic [15:0] wrap_angle(input logic [15:0] a);
    logic [15:0] r;
    r = (a >= FULL_TURN) ? (a - FULL_TURN) : a;
    return r;
  endfunction

  // Shortest signed rotation from one heading to another, -18000..17999.
  function automatic logic signed [16:0] shortest_err(input logic [15:0] from_a,
                                                      input logic [15:0] to_a);
    logic signed [16:0] diff;
    logic signed [16:0] res;
    diff = $signed({1'b0, to_a}) - $signed({1'b0, from_a});
    res  = diff;
    if (diff >= 17'sd0) begin
      if (diff >= 17'(HALF_TURN)) res = diff - $signed({1'b0, FULL_TURN});
    end else begin
      if (diff < -17'(HALF_TURN)) res = diff + $signed({1'b0, FULL_TURN});
    end
    return res;
  endfunction

  // Magnitude of a shortest rotation; it never exceeds 18000.
  function automatic logic [14:0] err_mag(input logic signed [16:0] e);
    logic signed [16:0] m;
    m = (e < 17'sd0) ? -e : e;
    return m[14:0];
  endfunction

endpackage

// File: hdl/orc_in_if.sv
interface orc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [15:0]        target_angle;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic [15:0]        compass_angle;
  logic               compass_fresh;

  modport source (
    output valid, op, target_angle, left_count, right_count, compass_angle, compass_fresh,
    input  ready
  );

  modport sink (
    input  valid, op, target_angle, left_count, right_count, compass_angle, compass_fresh,
    output ready
  );
endinterface

// File: hdl/orc_out_if.sv
interface orc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  left_speed;
  logic [7:0]  right_speed;
  logic [15:0] heading;
  logic [15:0] progress;
  logic        finished;
  logic        stalled;

  modport source (
    output valid, left_speed, right_speed, heading, progress, finished, stalled,
    input  ready
  );

  modport sink (
    input  valid, left_speed, right_speed, heading, progress, finished, stalled,
    output ready
  );
endinterface

// File: hdl/orc_cfg_if.sv
interface orc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] wdata;

  modport source (
    output valid, reg_index, wdata,
    input  ready
  );

  modport sink (
    input  valid, reg_index, wdata,
    output ready
  );
endinterface

// File: hdl/orc_cfg_regs.sv
module orc_cfg_regs import orc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  orc_cfg_if.sink   cfg_ch,
  output cfg_t      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken.
  assign cfg_ch.ready = 1'b1;

  // Decode the register index of a write transfer.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_ANGLE_PER_TICK: cfg_nxt.angle_per_tick = cfg_ch.wdata;
        CFG_CLOSE_ENOUGH:   cfg_nxt.close_enough   = cfg_ch.wdata[14:0];
        CFG_SLOW_THRESHOLD: cfg_nxt.slow_threshold = cfg_ch.wdata[14:0];
        CFG_STOP_SPEED:     cfg_nxt.stop_speed     = cfg_ch.wdata[7:0];
        CFG_FAST_FWD_SPEED: cfg_nxt.fast_fwd_speed = cfg_ch.wdata[7:0];
        CFG_FAST_REV_SPEED: cfg_nxt.fast_rev_speed = cfg_ch.wdata[7:0];
        CFG_SLOW_FWD_SPEED: cfg_nxt.slow_fwd_speed = cfg_ch.wdata[7:0];
        CFG_SLOW_REV_SPEED: cfg_nxt.slow_rev_speed = cfg_ch.wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_per_tick <= 16'd256;
      cfg_r.close_enough   <= 15'd100;
      cfg_r.slow_threshold <= 15'd1000;
      cfg_r.stop_speed     <= 8'd128;
      cfg_r.fast_fwd_speed <= 8'd160;
      cfg_r.fast_rev_speed <= 8'd96;
      cfg_r.slow_fwd_speed <= 8'd144;
      cfg_r.slow_rev_speed <= 8'd112;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/orc_turn_est.sv
module orc_turn_est import orc_pkg::*; (
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  input  logic [31:0]        last_left,
  input  logic [31:0]        last_right,
  input  logic [15:0]        angle_per_tick,
  input  logic               compass_fresh,
  output turn_est_t          est
);

  logic [31:0] dl;
  logic [31:0] dr;
  logic [31:0] al;
  logic [31:0] ar;
  logic [32:0] sum;
  logic [31:0] avg;
  logic [31:0] dis;
  logic [47:0] prod;
  logic [15:0] turn_sat;

  // Wrapping encoder deltas and their exact magnitudes.
  always_comb begin
    dl  = $unsigned(left_count) - last_left;
    dr  = $unsigned(right_count) - last_right;
    al  = dl[31] ? (~dl + 32'd1) : dl;
    ar  = dr[31] ? (~dr + 32'd1) : dr;
    sum = {1'b0, al} + {1'b0, ar};
    avg = sum[32:1];
    dis = (al > ar) ? (al - ar) : (ar - al);
  end

  // Average wheel travel scaled by the Q8 angle factor, saturated below a full turn.
  always_comb begin
    prod     = 48'(avg) * 48'(angle_per_tick);
    turn_sat = (prod[47:8] > 40'(MAX_TURN)) ? MAX_TURN : prod[23:8];
  end

  // Wheels that disagree with a fresh compass hand the heading to the compass.
  always_comb begin
    est.use_compass = (dis > MAX_WHEEL_DISAGREE) && compass_fresh;
    est.turn        = est.use_compass ? 16'd0 : turn_sat;
    est.dir_pos     = (dl != 32'd0) && !dl[31];
  end

endmodule

// File: hdl/orc_state_update.sv
module orc_state_update import orc_pkg::*; #(
  parameter int unsigned IDLE_ABORT_LIMIT = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  in_item_t    item,
  input  cfg_t        cfg,
  input  turn_est_t   est,
  output logic [31:0] last_left,
  output logic [31:0] last_right,
  output out_item_t   res
);

  localparam logic [7:0] ABORT_LIM = 8'(IDLE_ABORT_LIMIT);

  logic [31:0] last_left_r, last_left_nxt;
  logic [31:0] last_right_r, last_right_nxt;
  logic [15:0] cur_heading_r, cur_heading_nxt;
  logic [15:0] goal_heading_r, goal_heading_nxt;
  logic [14:0] needed_r, needed_nxt;
  logic [15:0] rotated_r, rotated_nxt;
  logic [7:0]  idle_ticks_r, idle_ticks_nxt;
  logic        busy_r, busy_nxt;

  logic [15:0]        tgt_w;
  logic [15:0]        cmp_w;
  logic signed [16:0] err;
  logic [14:0]        aerr;
  logic [14:0]        start_need;
  logic               fast;
  logic signed [17:0] h_sum;
  logic [15:0]        h_wrap;
  logic [16:0]        rot_sum;
  logic [15:0]        rot_sat;
  logic signed [17:0] rot_goal;
  logic [7:0]         idle_inc;
  logic [7:0]         ls;
  logic [7:0]         rs;
  logic               fin;
  logic               stall;

  // Angle arithmetic shared by the operations.
  always_comb begin
    tgt_w      = wrap_angle(item.target_angle);
    cmp_w      = wrap_angle(item.compass_angle);
    err        = shortest_err(cur_heading_r, goal_heading_r);
    aerr       = err_mag(err);
    start_need = err_mag(shortest_err(cur_heading_r, tgt_w));
    fast       = aerr > cfg.slow_threshold;

    if (est.dir_pos) h_sum = $signed({2'b0, cur_heading_r}) + $signed({2'b0, est.turn});
    else             h_sum = $signed({2'b0, cur_heading_r}) - $signed({2'b0, est.turn});
    if (h_sum >= $signed({2'b0, FULL_TURN}))  h_wrap = 16'(h_sum - $signed({2'b0, FULL_TURN}));
    else if (h_sum < 18'sd0)                  h_wrap = 16'(h_sum + $signed({2'b0, FULL_TURN}));
    else                                      h_wrap = h_sum[15:0];

    rot_sum  = {1'b0, rotated_r} + {1'b0, est.turn};
    rot_sat  = rot_sum[16] ? 16'hFFFF : rot_sum[15:0];
    rot_goal = $signed({3'b0, needed_r}) - $signed({3'b0, cfg.close_enough});
    idle_inc = (idle_ticks_r == 8'hFF) ? idle_ticks_r : idle_ticks_r + 8'd1;
  end

  // Next state and result of one item.
  always_comb begin
    last_left_nxt    = last_left_r;
    last_right_nxt   = last_right_r;
    cur_heading_nxt  = cur_heading_r;
    goal_heading_nxt = goal_heading_r;
    needed_nxt       = needed_r;
    rotated_nxt      = rotated_r;
    idle_ticks_nxt   = idle_ticks_r;
    busy_nxt         = busy_r;
    ls               = cfg.stop_speed;
    rs               = cfg.stop_speed;
    fin              = 1'b0;
    stall            = 1'b0;

    case (item.op)
      OP_START: begin
        goal_heading_nxt = tgt_w;
        last_left_nxt    = $unsigned(item.left_count);
        last_right_nxt   = $unsigned(item.right_count);
        needed_nxt       = start_need;
        rotated_nxt      = 16'd0;
        idle_ticks_nxt   = 8'd0;
        busy_nxt         = 1'b1;
        if (start_need <= cfg.close_enough) begin
          busy_nxt = 1'b0;
          fin      = 1'b1;
        end
      end
      OP_SET: begin
        cur_heading_nxt = tgt_w;
      end
      OP_TICK: begin
        if (busy_r) begin
          // Turn toward the goal, fast while far from it.
          if (err > 17'sd0) begin
            ls = fast ? cfg.fast_fwd_speed : cfg.slow_fwd_speed;
            rs = fast ? cfg.fast_rev_speed : cfg.slow_rev_speed;
          end else if (err < 17'sd0) begin
            ls = fast ? cfg.fast_rev_speed : cfg.slow_rev_speed;
            rs = fast ? cfg.fast_fwd_speed : cfg.slow_fwd_speed;
          end
          last_left_nxt   = $unsigned(item.left_count);
          last_right_nxt  = $unsigned(item.right_count);
          cur_heading_nxt = est.use_compass ? cmp_w : h_wrap;
          idle_ticks_nxt  = (est.turn == 16'd0) ? idle_inc : 8'd0;

          // End on a stall or once the rotation is close enough.
          if (idle_ticks_nxt > ABORT_LIM) begin
            fin   = 1'b1;
            stall = 1'b1;
          end else begin
            rotated_nxt = rot_sat;
            if ($signed({2'b0, rot_sat}) >= rot_goal) fin = 1'b1;
          end
          if (fin) begin
            busy_nxt = 1'b0;
            ls       = cfg.stop_speed;
            rs       = cfg.stop_speed;
          end
        end
      end
      default: ;
    endcase

    res.left_speed  = ls;
    res.right_speed = rs;
    res.heading     = cur_heading_nxt;
    res.progress    = rotated_nxt;
    res.finished    = fin;
    res.stalled     = stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_left_r    <= '0;
      last_right_r   <= '0;
      cur_heading_r  <= '0;
      goal_heading_r <= '0;
      needed_r       <= '0;
      rotated_r      <= '0;
      idle_ticks_r   <= '0;
      busy_r         <= 1'b0;
    end else if (go) begin
      last_left_r    <= last_left_nxt;
      last_right_r   <= last_right_nxt;
      cur_heading_r  <= cur_heading_nxt;
      goal_heading_r <= goal_heading_nxt;
      needed_r       <= needed_nxt;
      rotated_r      <= rotated_nxt;
      idle_ticks_r   <= idle_ticks_nxt;
      busy_r         <= busy_nxt;
    end
  end

  assign last_left  = last_left_r;
  assign last_right = last_right_r;

endmodule

// File: hdl/odometric_rotation_controller_core.sv
// Flow: an item transferred in is held in the input register and moves into the output
// register when that register is free or its result is being taken by out_ch.ready.
// Throughput: one item per cycle unless the output stalls, via one combinational pass
// (encoder deltas, a 32x16 multiply, heading and rotation update) and the output register.
// Reset (synchronous, rst_n low): heading, goal, counts and counters clear, no turn is
// active, both pipeline stages empty, registers return to their documented defaults.
module odometric_rotation_controller_core import orc_pkg::*; #(
  parameter int unsigned IDLE_ABORT_LIMIT = 40
) (
  input  logic       clk,
  input  logic       rst_n,
  orc_cfg_if.sink    cfg_ch,
  orc_in_if.sink     in_ch,
  orc_out_if.source  out_ch
);

  cfg_t      cfg;
  in_item_t  item_r;
  logic      item_v_r;
  out_item_t res;
  out_item_t out_r;
  logic      out_v_r;
  logic      adv;
  logic      go;
  turn_est_t est;
  logic [31:0] last_left;
  logic [31:0] last_right;

  // Configuration registers.
  orc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Pipeline flow: the held item moves on whenever the output register is free.
  assign adv         = !out_v_r || out_ch.ready;
  assign go          = item_v_r && adv;
  assign in_ch.ready = !item_v_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.op            <= op_t'(in_ch.op);
      item_r.target_angle  <= in_ch.target_angle;
      item_r.left_count    <= in_ch.left_count;
      item_r.right_count   <= in_ch.right_count;
      item_r.compass_angle <= in_ch.compass_angle;
      item_r.compass_fresh <= in_ch.compass_fresh;
    end
  end

  // Encoder odometry for the held item.
  orc_turn_est u_est (
    .left_count     (item_r.left_count),
    .right_count    (item_r.right_count),
    .last_left      (last_left),
    .last_right     (last_right),
    .angle_per_tick (cfg.angle_per_tick),
    .compass_fresh  (item_r.compass_fresh),
    .est            (est)
  );

  // Controller state and result formation.
  orc_state_update #(
    .IDLE_ABORT_LIMIT (IDLE_ABORT_LIMIT)
  ) u_upd (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .item       (item_r),
    .cfg        (cfg),
    .est        (est),
    .last_left  (last_left),
    .last_right (last_right),
    .res        (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.left_speed  = out_r.left_speed;
  assign out_ch.right_speed = out_r.right_speed;
  assign out_ch.heading     = out_r.heading;
  assign out_ch.progress    = out_r.progress;
  assign out_ch.finished    = out_r.finished;
  assign out_ch.stalled     = out_r.stalled;

endmodule
